// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file of the scheduler unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/fsts_pkg.sv =====
// Types and constants of the fair-share task scheduler.
package fsts_pkg;

    localparam int MAX_TASKS_DEF = 32;
    localparam int LIVE_W        = 6;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_ZERO  = 2'd3
    } fsts_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN,
        ST_PICK,
        ST_RUN,
        ST_EMIT
    } fsts_state_t;

    // One table entry as it sits in the slot memory.
    typedef struct packed {
        logic [31:0] order;
        logic [15:0] elapsed;
        logic [15:0] duration;
        logic [31:0] vruntime;
        logic [7:0]  id;
    } fsts_slot_t;

    // One report as it leaves the block.
    typedef struct packed {
        logic              finished;
        logic              idle;
        logic [7:0]        shown_id;
        logic [LIVE_W-1:0] live_tasks;
        logic [31:0]       tick_number;
        fsts_kind_t        kind;
    } fsts_res_t;

endpackage

// ===== rtl/fair_share_task_scheduler_unit.sv =====
// Fair-share task scheduler: slot memory, scan sequencer and report register.
//
// Input channel s_*: one transaction is either an add (s_tuser = 0) that queues a
// task with vruntime equal to the current vruntime floor, or a tick (s_tuser = 1).
// Every input transaction yields exactly one report transaction on m_*, in order.
// Waiting tasks live in a MAX_TASKS-entry memory with a registered read port;
// per-slot valid bits sit in flip-flops and are cleared at reset at once.
// A rejected add passes straight to the emit state; an accepted add first walks
// the valid bits for the lowest free slot. A tick that needs a pick sweeps the
// whole memory, one entry per cycle, to find the smallest and the second
// smallest vruntime. A tick that keeps the running task skips the sweep. The
// memory sweep sets the rate; one item is worked on at a time.
// s_tready is high while the sequencer is idle, including while a finished report
// still waits in the output register, so the next item overlaps a stalled output.
// If m_tready stays low, the following report holds in the sequencer until the
// output register frees. Reset (aresetn low, synchronous) empties the table and
// clears the running task, vruntime floor, tick count and the output register.
module fair_share_task_scheduler_unit
    import fsts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] task_id, [23:8] task_duration
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] tick_number, [37:32] live_tasks,
                                   // [45:38] shown_id, [46] idle, [47] finished
    output logic [1:0]  m_tuser    // [1:0] report_kind
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    // Control state
    fsts_state_t          state_reg, state_next;
    logic [MAX_TASKS-1:0] slot_valid_reg, slot_valid_next;
    logic [31:0]          seq_reg, seq_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [7:0]           cur_id_reg, cur_id_next;
    logic [31:0]          cur_vr_reg, cur_vr_next;
    logic [15:0]          cur_dur_reg, cur_dur_next;
    logic [15:0]          cur_el_reg, cur_el_next;
    logic [31:0]          min_vr_reg, min_vr_next;
    logic [31:0]          tick_reg, tick_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 cmp_pend_reg, cmp_pend_next;
    logic                 preempt_reg, preempt_next;
    logic                 free_found_reg, free_found_next;
    logic                 best_found_reg, best_found_next;
    logic                 best_cur_reg, best_cur_next;
    logic                 sec_found_reg, sec_found_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    fsts_slot_t           best_slot_reg, best_slot_next;
    logic [31:0]          best_age_reg, best_age_next;
    logic [31:0]          sec_vr_reg, sec_vr_next;
    logic [7:0]           id_reg, id_next;
    logic [15:0]          dur_reg, dur_next;
    fsts_res_t            res_reg, res_next;
    fsts_res_t            m_res_reg, m_res_next;

    // Slot memory
    fsts_slot_t           slot_mem [MAX_TASKS];
    fsts_slot_t           mem_q_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    fsts_slot_t           mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    logic [IDX_W-1:0]     rd_idx;
    logic [31:0]          entry_age;
    logic                 entry_better;
    logic                 scan_reading;
    logic [15:0]          el_inc;

    assign rd_idx       = rd_cnt_reg[IDX_W-1:0];
    assign scan_reading = (rd_cnt_reg != CNT_W'(MAX_TASKS));
    assign entry_age    = seq_reg - mem_q_reg.order;
    assign entry_better = !best_found_reg
                       || (mem_q_reg.vruntime < best_slot_reg.vruntime)
                       || ((mem_q_reg.vruntime == best_slot_reg.vruntime)
                           && (entry_age > best_age_reg));
    assign el_inc       = cur_el_reg + 16'd1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.finished, m_res_reg.idle, m_res_reg.shown_id,
                       m_res_reg.live_tasks, m_res_reg.tick_number};
    assign m_tuser  = m_res_reg.kind;

    // Reads and writes never overlap: writes happen only in FIND and PICK,
    // reads only during SCAN, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= slot_mem[mem_raddr];
    end

    always_comb begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        seq_next        = seq_reg;
        cur_valid_next  = cur_valid_reg;
        cur_id_next     = cur_id_reg;
        cur_vr_next     = cur_vr_reg;
        cur_dur_next    = cur_dur_reg;
        cur_el_next     = cur_el_reg;
        min_vr_next     = min_vr_reg;
        tick_next       = tick_reg;
        count_next      = count_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_pend_next   = cmp_pend_reg;
        preempt_next    = preempt_reg;
        free_found_next = free_found_reg;
        best_found_next = best_found_reg;
        best_cur_next   = best_cur_reg;
        sec_found_next  = sec_found_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_idx_next   = free_idx_reg;
        best_idx_next   = best_idx_reg;
        best_slot_next  = best_slot_reg;
        best_age_next   = best_age_reg;
        sec_vr_next     = sec_vr_reg;
        id_next         = id_reg;
        dur_next        = dur_reg;
        res_next        = res_reg;
        m_res_next      = m_res_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next         = s_tdata[7:0];
                    dur_next        = s_tdata[23:8];
                    rd_cnt_next     = '0;
                    cmp_pend_next   = 1'b0;
                    free_found_next = 1'b0;
                    sec_found_next  = 1'b0;
                    preempt_next    = 1'b0;
                    best_found_next = 1'b0;
                    best_cur_next   = 1'b0;
                    res_next.kind        = KIND_TICK;
                    res_next.tick_number = tick_reg;
                    res_next.live_tasks  = LIVE_W'(count_reg);
                    res_next.shown_id    = s_tdata[7:0];
                    res_next.idle        = 1'b0;
                    res_next.finished    = 1'b0;
                    if (s_tuser[0] == OP_TICK) begin
                        if (cur_valid_reg && (cur_vr_reg > min_vr_reg)) begin
                            // Put the running task back as the youngest entry;
                            // it joins the sweep without a memory round trip.
                            preempt_next    = 1'b1;
                            seq_next        = seq_reg + 32'd1;
                            best_found_next = 1'b1;
                            best_cur_next   = 1'b1;
                            best_slot_next  = '{order: seq_reg, elapsed: cur_el_reg,
                                                duration: cur_dur_reg,
                                                vruntime: cur_vr_reg, id: cur_id_reg};
                            best_age_next   = 32'd1;
                            state_next      = ST_SCAN;
                        end else if (cur_valid_reg) begin
                            state_next = ST_RUN;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else if (s_tdata[23:8] == 16'd0) begin
                        res_next.kind = KIND_ZERO;
                        state_next    = ST_EMIT;
                    end else if (count_reg >= CNT_W'(MAX_TASKS)) begin
                        res_next.kind = KIND_FULL;
                        state_next    = ST_EMIT;
                    end else begin
                        state_next = ST_FIND;
                    end
                end
            end

            ST_FIND: begin
                // Walk the valid bits for the lowest free slot.
                if (!slot_valid_reg[rd_idx]) begin
                    mem_we                  = 1'b1;
                    mem_waddr               = rd_idx;
                    mem_wdata               = '{order: seq_reg, elapsed: 16'd0,
                                                duration: dur_reg,
                                                vruntime: min_vr_reg, id: id_reg};
                    slot_valid_next[rd_idx] = 1'b1;
                    seq_next                = seq_reg + 32'd1;
                    count_next              = count_reg + CNT_W'(1);
                    res_next.kind           = KIND_ADDED;
                    res_next.live_tasks     = LIVE_W'(count_reg + CNT_W'(1));
                    state_next              = ST_EMIT;
                end else begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
            end

            ST_SCAN: begin
                // Read stage: issue one address, note the first free slot.
                if (scan_reading) begin
                    mem_raddr     = rd_idx;
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = rd_idx;
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                    if (!free_found_reg && !slot_valid_reg[rd_idx]) begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx;
                    end
                end else begin
                    cmp_pend_next = 1'b0;
                end
                // Compare stage: keep the best entry and the runner-up vruntime.
                if (cmp_pend_reg && slot_valid_reg[cmp_idx_reg]) begin
                    if (entry_better) begin
                        if (best_found_reg) begin
                            sec_found_next = 1'b1;
                            sec_vr_next    = best_slot_reg.vruntime;
                        end
                        best_found_next = 1'b1;
                        best_cur_next   = 1'b0;
                        best_idx_next   = cmp_idx_reg;
                        best_slot_next  = mem_q_reg;
                        best_age_next   = entry_age;
                    end else if (!sec_found_reg || (mem_q_reg.vruntime < sec_vr_reg)) begin
                        sec_found_next = 1'b1;
                        sec_vr_next    = mem_q_reg.vruntime;
                    end
                end
                if (cmp_pend_reg && (cmp_idx_reg == IDX_W'(MAX_TASKS - 1))) begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK: begin
                if (best_found_reg) begin
                    cur_valid_next = 1'b1;
                    cur_id_next    = best_slot_reg.id;
                    cur_vr_next    = best_slot_reg.vruntime;
                    cur_dur_next   = best_slot_reg.duration;
                    cur_el_next    = best_slot_reg.elapsed;
                    if (!best_cur_reg) begin
                        slot_valid_next[best_idx_reg] = 1'b0;
                        // The preempted task lost: park it in the free slot.
                        if (preempt_reg) begin
                            mem_we                        = 1'b1;
                            mem_waddr                     = free_idx_reg;
                            mem_wdata                     = '{order: seq_reg - 32'd1,
                                                              elapsed: cur_el_reg,
                                                              duration: cur_dur_reg,
                                                              vruntime: cur_vr_reg,
                                                              id: cur_id_reg};
                            slot_valid_next[free_idx_reg] = 1'b1;
                        end
                    end
                    if (sec_found_reg) begin
                        min_vr_next = sec_vr_reg;
                    end
                end
                state_next = ST_RUN;
            end

            ST_RUN: begin
                res_next.kind        = KIND_TICK;
                res_next.tick_number = tick_reg;
                res_next.live_tasks  = LIVE_W'(count_reg);
                res_next.shown_id    = cur_valid_reg ? cur_id_reg : 8'd0;
                res_next.idle        = !cur_valid_reg;
                res_next.finished    = 1'b0;
                if (cur_valid_reg) begin
                    cur_vr_next = cur_vr_reg + 32'd1;
                    cur_el_next = el_inc;
                    if (el_inc == cur_dur_reg) begin
                        res_next.finished = 1'b1;
                        cur_valid_next    = 1'b0;
                        if (count_reg != '0) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                tick_next  = tick_reg + 32'd1;
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                // Hold the report until the output register frees.
                if (!m_valid_reg || m_tready) begin
                    m_res_next   = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            seq_reg        <= '0;
            cur_valid_reg  <= 1'b0;
            cur_id_reg     <= '0;
            cur_vr_reg     <= '0;
            cur_dur_reg    <= '0;
            cur_el_reg     <= '0;
            min_vr_reg     <= '0;
            tick_reg       <= '0;
            count_reg      <= '0;
            rd_cnt_reg     <= '0;
            cmp_pend_reg   <= 1'b0;
            preempt_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            best_cur_reg   <= 1'b0;
            sec_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            seq_reg        <= seq_next;
            cur_valid_reg  <= cur_valid_next;
            cur_id_reg     <= cur_id_next;
            cur_vr_reg     <= cur_vr_next;
            cur_dur_reg    <= cur_dur_next;
            cur_el_reg     <= cur_el_next;
            min_vr_reg     <= min_vr_next;
            tick_reg       <= tick_next;
            count_reg      <= count_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_pend_reg   <= cmp_pend_next;
            preempt_reg    <= preempt_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            best_cur_reg   <= best_cur_next;
            sec_found_reg  <= sec_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg   <= cmp_idx_next;
        free_idx_reg  <= free_idx_next;
        best_idx_reg  <= best_idx_next;
        best_slot_reg <= best_slot_next;
        best_age_reg  <= best_age_next;
        sec_vr_reg    <= sec_vr_next;
        id_reg        <= id_next;
        dur_reg       <= dur_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > CNT_W'(MAX_TASKS), "task count above table size")
    `ASSERT_PROP(a_cur_elapsed, aclk, aresetn, cur_valid_reg |-> (cur_el_reg < cur_dur_reg), "running task past its duration")
    `ASSERT_PROP(a_pick_valid, aclk, aresetn, (state_reg == ST_PICK && best_found_reg && !best_cur_reg) |-> slot_valid_reg[best_idx_reg], "picked slot not valid")
    `ASSERT_PROP(a_park_free, aclk, aresetn, (state_reg == ST_PICK && preempt_reg && !best_cur_reg) |-> (free_found_reg && !slot_valid_reg[free_idx_reg]), "no free slot for preempted task")

endmodule

// ===== sim/fsts_schedule_checker.sv =====
// Scoreboard for the fair-share task scheduler: predicts each report and compares.
module fsts_schedule_checker
    import fsts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] task_id, [23:8] task_duration
    input  logic [0:0]  s_tuser,   // [0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [31:0] tick_number, [37:32] live_tasks,
                                   // [45:38] shown_id, [46] idle, [47] finished
    input  logic [1:0]  m_tuser,   // [1:0] report_kind
    output int          fault_count,
    output int          pending_reports,
    output int          n_ticks,
    output int          n_idle,
    output int          n_done,
    output int          n_preempt,
    output int          n_added,
    output int          n_full,
    output int          n_zero,
    output int          peak_live
);

    // Waiting tasks, one entry per slot.
    bit        slot_busy [MAX_TASKS];
    bit [7:0]  slot_tid  [MAX_TASKS];
    bit [31:0] slot_vrt  [MAX_TASKS];
    bit [15:0] slot_len  [MAX_TASKS];
    bit [15:0] slot_ran  [MAX_TASKS];
    bit [31:0] slot_seq  [MAX_TASKS];
    bit [31:0] next_seq;

    // Running task and scheduler bookkeeping.
    bit        run_busy;
    bit [7:0]  run_tid;
    bit [31:0] run_vrt;
    bit [15:0] run_len;
    bit [15:0] run_ran;
    bit [31:0] vrt_floor;
    bit [31:0] tick_no;
    int        live_cnt;

    fsts_res_t report_queue [$];

    initial begin
        fault_count     = 0;
        pending_reports = 0;
        n_ticks         = 0;
        n_idle          = 0;
        n_done          = 0;
        n_preempt       = 0;
        n_added         = 0;
        n_full          = 0;
        n_zero          = 0;
        peak_live       = 0;
    end

    // Store a task in the lowest free slot and stamp its insertion order.
    function automatic void park_task(input bit [7:0] tid, input bit [31:0] vrt,
                                      input bit [15:0] len, input bit [15:0] ran);
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (!slot_busy[i]) begin
                slot_busy[i] = 1'b1;
                slot_tid[i]  = tid;
                slot_vrt[i]  = vrt;
                slot_len[i]  = len;
                slot_ran[i]  = ran;
                slot_seq[i]  = next_seq;
                next_seq++;
                return;
            end
        end
    endfunction

    // Slot with the smallest vruntime, oldest on ties; MAX_TASKS when empty.
    function automatic int oldest_min();
        int        best;
        bit [31:0] age_i;
        bit [31:0] age_b;
        best = MAX_TASKS;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (slot_busy[i]) begin
                if (best == MAX_TASKS) begin
                    best = i;
                end else begin
                    age_i = next_seq - slot_seq[i];
                    age_b = next_seq - slot_seq[best];
                    if (slot_vrt[i] < slot_vrt[best] ||
                        (slot_vrt[i] == slot_vrt[best] && age_i > age_b))
                        best = i;
                end
            end
        end
        return best;
    endfunction

    // Advance the scheduler by one transaction and return the report it causes.
    function automatic fsts_res_t predict_report(input logic op, input logic [7:0] tid,
                                                 input logic [15:0] len);
        fsts_res_t r;
        int        k;
        r             = '0;
        r.kind        = KIND_TICK;
        r.tick_number = tick_no;
        if (op == OP_ADD) begin
            if (len == 16'd0) begin
                r.kind = KIND_ZERO;
            end else if (live_cnt >= MAX_TASKS) begin
                r.kind = KIND_FULL;
            end else begin
                r.kind = KIND_ADDED;
                park_task(tid, vrt_floor, len, 16'd0);
                live_cnt++;
            end
            r.shown_id   = tid;
            r.live_tasks = live_cnt[LIVE_W-1:0];
        end else begin
            if (run_busy && run_vrt > vrt_floor) begin
                park_task(run_tid, run_vrt, run_len, run_ran);
                run_busy = 1'b0;
                n_preempt++;
            end
            if (!run_busy) begin
                k = oldest_min();
                if (k < MAX_TASKS) begin
                    run_busy     = 1'b1;
                    run_tid      = slot_tid[k];
                    run_vrt      = slot_vrt[k];
                    run_len      = slot_len[k];
                    run_ran      = slot_ran[k];
                    slot_busy[k] = 1'b0;
                    k = oldest_min();
                    if (k < MAX_TASKS)
                        vrt_floor = slot_vrt[k];
                end
            end
            r.live_tasks = live_cnt[LIVE_W-1:0];
            if (run_busy) begin
                run_vrt++;
                run_ran++;
                r.shown_id = run_tid;
                if (run_ran == run_len) begin
                    r.finished = 1'b1;
                    run_busy   = 1'b0;
                    if (live_cnt > 0)
                        live_cnt--;
                end
            end else begin
                r.idle = 1'b1;
            end
            tick_no++;
        end
        return r;
    endfunction

    function automatic string show_report(input fsts_res_t r);
        return $sformatf("kind=%0d tick=%0d live=%0d id=%0d idle=%0b finished=%0b",
                         r.kind, r.tick_number, r.live_tasks, r.shown_id, r.idle,
                         r.finished);
    endfunction

    always @(posedge aclk) begin
        fsts_res_t want;
        fsts_res_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = predict_report(s_tuser[0], s_tdata[7:0], s_tdata[23:8]);
                report_queue.insert(report_queue.size(), want);
                case (want.kind)
                    KIND_TICK: begin
                        n_ticks++;
                        n_idle += want.idle;
                        n_done += want.finished;
                    end
                    KIND_ADDED: n_added++;
                    KIND_FULL:  n_full++;
                    default:    n_zero++;
                endcase
                if (want.live_tasks > peak_live)
                    peak_live = want.live_tasks;
            end
            if (m_tvalid && m_tready) begin
                got = fsts_res_t'({m_tdata, m_tuser});
                if (report_queue.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected report: %s", show_report(got));
                end else begin
                    want = report_queue.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("report mismatch\n  expected %s\n  actual   %s",
                                     show_report(want), show_report(got));
                    end
                end
            end
        end
        pending_reports <= report_queue.size();
    end

endmodule

// ===== sim/fair_share_task_scheduler_unit_test.sv =====
// Stimulus and verdict for the fair-share task scheduler unit.
module fair_share_task_scheduler_unit_test;
    import fsts_pkg::*;

    localparam int N_RANDOM     = 1350;    // random transactions after the directed part
    localparam int CYCLE_LIMIT  = 400000;  // several times the slowest legal run
    localparam int DRAIN_CYCLES = 80;      // covers a full-table pick sweep twice
    localparam int HOLD_START   = 6000;    // receiver cycle where the long hold-off begins
    localparam int HOLD_LEN     = 400;

    typedef enum {RX_OPEN, RX_COIN, RX_CADENCE, RX_CHOKE} rx_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [7:0] task_id, [23:8] task_duration
    logic [0:0]  s_tuser  = '0;   // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [31:0] tick_number, [37:32] live_tasks,
                                  // [45:38] shown_id, [46] idle, [47] finished
    logic [1:0]  m_tuser;         // [1:0] report_kind

    int fault_count, pending_reports;
    int n_ticks, n_idle, n_done, n_preempt, n_added, n_full, n_zero, peak_live;

    int cycle_no   = 0;
    int burst_left = 0;

    fair_share_task_scheduler_unit #(
        .MAX_TASKS (MAX_TASKS_DEF)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fsts_schedule_checker #(
        .MAX_TASKS (MAX_TASKS_DEF)
    ) scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fault_count     (fault_count),
        .pending_reports (pending_reports),
        .n_ticks         (n_ticks),
        .n_idle          (n_idle),
        .n_done          (n_done),
        .n_preempt       (n_preempt),
        .n_added         (n_added),
        .n_full          (n_full),
        .n_zero          (n_zero),
        .peak_live       (peak_live)
    );

    always #2 aclk = ~aclk;

    // Watchdog: kill the run if it hangs anywhere.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_no, pending_reports);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: switch between back-pressure patterns, each for a random stretch, and
    // once hold off for a long stretch so the block fills up and stalls its input.
    int       rx_cycles    = 0;
    int       rx_mode_left = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    always @(posedge aclk) begin
        rx_cycles++;
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 128);
        end
        rx_mode_left--;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= ($urandom_range(0, 1) == 1);
                RX_CADENCE: m_tready <= ((rx_cycles % 5) < 3);
                default:    m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Offer one transaction and hold it until accepted. The sender works in bursts;
    // when a burst runs out, drop tvalid for a random gap and pick the next length.
    task automatic offer(input logic op, input logic [7:0] tid, input logic [15:0] len);
        s_tvalid <= 1'b1;
        s_tdata  <= {len, tid};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    initial begin
        int         n_random;
        int         phase_left;
        int         n_adds;
        int         pick;
        bit         filling;
        bit         tidy;
        logic [7:0] tid;
        logic [15:0] len;

        n_random   = 0;
        phase_left = 0;
        filling    = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle tick, zero-duration reject, extreme ids and durations,
        // a repeated id, a one-unit task, then ticks that preempt and break ties.
        offer(OP_TICK, 8'h00, 16'h0000);
        offer(OP_ADD,  8'h00, 16'h0000);
        offer(OP_ADD,  8'hFF, 16'h0001);
        offer(OP_ADD,  8'h00, 16'hFFFF);
        offer(OP_ADD,  8'hFF, 16'h0003);
        offer(OP_TICK, 8'hFF, 16'hFFFF);
        repeat (6) offer(OP_TICK, 8'h00, 16'h0000);
        offer(OP_ADD,  8'hA5, 16'h5A5A);
        offer(OP_TICK, 8'h5A, 16'hA5A5);
        offer(OP_ADD,  8'h10, 16'h0002);
        offer(OP_ADD,  8'h11, 16'h0002);
        offer(OP_TICK, 8'h00, 16'h0000);
        offer(OP_TICK, 8'h00, 16'h0000);

        // Random: each tick is preceded by its arrivals. Fill phases pile on short
        // tasks until the table overflows; drain phases let them run out.
        while (n_random < N_RANDOM) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = filling ? $urandom_range(15, 25) : $urandom_range(40, 80);
            end
            phase_left--;
            n_adds = filling ? $urandom_range(2, 6) : $urandom_range(0, 1);
            // Mostly ascending ids as a real arrival list; now and then scrambled.
            tidy = ($urandom_range(0, 7) != 0);
            tid  = 8'($urandom_range(0, 255));
            for (int j = 0; j < n_adds; j++) begin
                if (tidy && j > 0)
                    tid = 8'($urandom_range(tid, 255));
                else if (j > 0)
                    tid = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 127);
                if (pick == 0)
                    len = 16'($urandom_range(0, 65535));
                else if (pick < 6)
                    len = 16'd0;
                else
                    len = filling ? 16'($urandom_range(1, 6)) : 16'($urandom_range(1, 4));
                offer(OP_ADD, tid, len);
                n_random++;
            end
            offer(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            n_random++;
        end

        // Drain: let the count settle, wait out every report, then linger.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d ticks (%0d idle, %0d preempted, %0d completed) in %0d cycles",
                 n_ticks, n_idle, n_preempt, n_done, cycle_no);
        $display("adds: %0d accepted, %0d refused full, %0d refused zero; peak %0d live",
                 n_added, n_full, n_zero, peak_live);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatching reports", fault_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== fair_share_task_scheduler_unit.f =====
+incdir+rtl
rtl/fsts_pkg.sv
rtl/fair_share_task_scheduler_unit.sv
sim/fsts_schedule_checker.sv
sim/fair_share_task_scheduler_unit_test.sv
